### hw/rtl/hss_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the half-step stepper controller.
// No dependencies.
package hss_pkg;

    // operating modes, encoded as reported on the result beat
    typedef enum logic [2:0] {
        M_IDLE     = 3'd0,
        M_FWD      = 3'd1,
        M_REV      = 3'd2,
        M_SYNCWAIT = 3'd3,
        M_SEEK     = 3'd4,
        M_FINDMIN  = 3'd5,
        M_FINDMAX  = 3'd6,
        M_DDA      = 3'd7
    } mode_t;

    // command codes on the input channel
    localparam logic [3:0] CMD_TICK      = 4'd0;
    localparam logic [3:0] CMD_SYNC      = 4'd1;
    localparam logic [3:0] CMD_RUN_FWD   = 4'd2;
    localparam logic [3:0] CMD_RUN_REV   = 4'd3;
    localparam logic [3:0] CMD_LOAD_POS  = 4'd4;
    localparam logic [3:0] CMD_SEEK      = 4'd5;
    localparam logic [3:0] CMD_RELEASE   = 4'd6;
    localparam logic [3:0] CMD_CALIBRATE = 4'd7;
    localparam logic [3:0] CMD_DDA       = 4'd8;

    // sync strobe actions
    localparam logic [1:0] SYNC_OFF        = 2'd0;
    localparam logic [1:0] SYNC_START_SEEK = 2'd1;
    localparam logic [1:0] SYNC_STEP_FWD   = 2'd2;
    localparam logic [1:0] SYNC_STEP_BACK  = 2'd3;

    // configuration register indexes
    localparam int          CFG_INDEX_BITS  = 2;
    localparam int          CFG_DATA_BITS   = 8;
    localparam logic [1:0]  CFG_NOTIFY_ADDR = 2'd0;
    localparam logic [1:0]  CFG_SYNC_MODE   = 2'd1;

    localparam logic [7:0]  NO_NOTIFY       = 8'd255;

    localparam logic        KIND_SEEK       = 1'b0;
    localparam logic        KIND_CALIB      = 1'b1;

    // one result beat
    typedef struct packed {
        logic [3:0]         coil_drive;
        logic signed [15:0] position;
        logic signed [15:0] range_max;
        logic [7:0]         run_rate;
        mode_t              mode;
        logic               sync_pulse;
        logic               notify_valid;
        logic               notify_kind;
    } result_t;

    // half-step coil sequence
    function automatic logic [3:0] phase_pattern(input logic [2:0] phase);
        logic [3:0] pat;
        unique case (phase)
            3'd0: pat = 4'b0001;
            3'd1: pat = 4'b0011;
            3'd2: pat = 4'b0010;
            3'd3: pat = 4'b0110;
            3'd4: pat = 4'b0100;
            3'd5: pat = 4'b1100;
            3'd6: pat = 4'b1000;
            3'd7: pat = 4'b1001;
            default: pat = 4'b0000;
        endcase
        return pat;
    endfunction

endpackage

### hw/rtl/half_step_stepper_controller.sv
`timescale 1ns / 1ps
// Half-step stepper controller: command decode, step state and result buffering.
// Depends on hss_pkg.
//
// Usage:
//   Input channel (s_*): one beat per event - step tick, sync strobe or command,
//   with the limit-switch levels sampled alongside. Result channel (m_*): exactly
//   one beat per input beat, showing coils, position, range, rate, mode and the
//   sync / notify flags after that event.
//   Configuration: cfg_wr_en with cfg_index / cfg_wdata writes notify address (0)
//   or sync mode (1); other indexes are ignored. Write only while idle.
//   Result: each event's result is registered into the result register, or into
//   the skid entry while the result register is held. Throughput: one beat per
//   cycle while the receiver keeps up; the whole state update is a single compare /
//   increment / add pass between the state registers and the result register.
//   Stall: a result register plus one skid entry; with the receiver stalled the
//   block takes one more beat, then drops s_ready until the output drains.
//   Reset: synchronous, active low. Coils off, position, range and DDA state zero,
//   mode idle, rate zero, notify address 255 (disabled), sync mode none,
//   no result pending.
module half_step_stepper_controller #(
    parameter int POSITION_BITS = 16
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,

    input  logic                                 cfg_wr_en,
    input  logic [hss_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [hss_pkg::CFG_DATA_BITS-1:0]    cfg_wdata,

    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [3:0]                           s_cmd,
    input  logic [7:0]                           s_rate_value,
    input  logic signed [15:0]                   s_target_position,
    input  logic signed [15:0]                   s_load_value,
    input  logic signed [15:0]                   s_minor_delta,
    input  logic                                 s_min_switch_n,
    input  logic                                 s_max_switch_n,

    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [3:0]                           m_coil_drive,
    output logic signed [15:0]                   m_position,
    output logic signed [15:0]                   m_range_max,
    output logic [7:0]                           m_run_rate,
    output logic [2:0]                           m_mode,
    output logic                                 m_sync_pulse,
    output logic                                 m_notify_valid,
    output logic                                 m_notify_kind
);

    localparam int PB = POSITION_BITS;
    localparam int EB = POSITION_BITS + 2;   // DDA error accumulator
    localparam int MB = POSITION_BITS + 1;   // DDA major delta

    // configuration
    logic [7:0] notify_addr_reg;
    logic [1:0] sync_mode_reg;

    // step state
    logic [2:0]           phase_reg,    phase_next;
    logic [3:0]           pattern_reg,  pattern_next;
    logic signed [PB-1:0] position_reg, position_next;
    logic signed [PB-1:0] target_reg,   target_next;
    logic signed [PB-1:0] max_found_reg, max_found_next;
    hss_pkg::mode_t       mode_reg,     mode_next;
    logic [7:0]           rate_reg,     rate_next;
    logic signed [EB-1:0] err_reg,      err_next;
    logic [MB-1:0]        major_reg,    major_next;
    logic signed [15:0]   minor_reg,    minor_next;

    // result buffering
    logic             out_valid_reg, skid_valid_reg;
    hss_pkg::result_t out_reg, skid_reg, res;

    logic accept, out_free;

    // datapath helpers
    logic signed [31:0]   tgt_ext, ld_ext, pos_out_ext, max_out_ext;
    logic signed [PB-1:0] tgt_w, ld_w;
    logic signed [PB:0]   diff;
    logic signed [33:0]   err_sum;
    logic signed [EB-1:0] err_a, err_b;
    logic signed [EB+1:0] err_dbl, major_ext;
    logic                 pos_lt, pos_gt, dda_over;
    logic                 do_fwd, do_back, pulse, notify, kind;
    logic [2:0]           phase_fwd, phase_back;

    assign accept   = s_valid && s_ready;
    assign out_free = !out_valid_reg || m_ready;
    assign s_ready  = !skid_valid_reg;

    // fit 16-bit fields to the position width
    assign tgt_ext = 32'(s_target_position);
    assign ld_ext  = 32'(s_load_value);
    assign tgt_w   = tgt_ext[PB-1:0];
    assign ld_w    = ld_ext[PB-1:0];

    assign pos_lt = position_reg < target_reg;
    assign pos_gt = position_reg > target_reg;

    assign diff = (PB+1)'(tgt_w) - (PB+1)'(position_reg);

    // Bresenham error update
    assign err_sum   = 34'(err_reg) + 34'(minor_reg);
    assign err_a     = err_sum[EB-1:0];
    assign err_dbl   = {err_a[EB-1], err_a, 1'b0};
    assign major_ext = {3'b000, major_reg};
    assign dda_over  = err_dbl > major_ext;
    assign err_b     = err_a - $signed({1'b0, major_reg});

    assign phase_fwd  = phase_reg + 3'd1;
    assign phase_back = phase_reg - 3'd1;

    always_comb begin
        phase_next     = phase_reg;
        pattern_next   = pattern_reg;
        position_next  = position_reg;
        target_next    = target_reg;
        max_found_next = max_found_reg;
        mode_next      = mode_reg;
        rate_next      = rate_reg;
        err_next       = err_reg;
        major_next     = major_reg;
        minor_next     = minor_reg;
        do_fwd         = 1'b0;
        do_back        = 1'b0;
        pulse          = 1'b0;
        notify         = 1'b0;
        kind           = hss_pkg::KIND_SEEK;

        unique case (s_cmd)
            hss_pkg::CMD_TICK: begin
                if (rate_reg != 8'd0) begin
                    unique case (mode_reg)
                        hss_pkg::M_IDLE: rate_next = 8'd0;
                        hss_pkg::M_FWD:  do_fwd = 1'b1;
                        hss_pkg::M_REV:  do_back = 1'b1;
                        hss_pkg::M_SEEK: begin
                            if (pos_lt) begin
                                do_fwd = 1'b1;
                            end else if (pos_gt) begin
                                do_back = 1'b1;
                            end else begin
                                rate_next = 8'd0;
                                notify    = 1'b1;
                            end
                        end
                        hss_pkg::M_FINDMIN: begin
                            if (!s_min_switch_n) begin
                                position_next = '0;
                                mode_next     = hss_pkg::M_FINDMAX;
                            end else begin
                                do_back = 1'b1;
                            end
                        end
                        hss_pkg::M_FINDMAX: begin
                            if (!s_max_switch_n) begin
                                max_found_next = position_reg;
                                mode_next      = hss_pkg::M_IDLE;
                                notify         = 1'b1;
                                kind           = hss_pkg::KIND_CALIB;
                            end else begin
                                do_fwd = 1'b1;
                            end
                        end
                        hss_pkg::M_DDA: begin
                            if (!pos_lt && !pos_gt) begin
                                mode_next = hss_pkg::M_IDLE;
                                rate_next = 8'd0;
                            end else begin
                                do_fwd  = pos_lt;
                                do_back = pos_gt;
                                pulse   = dda_over;
                                err_next = dda_over ? err_b : err_a;
                            end
                        end
                        default: ;  // syncwait: ticks ignored
                    endcase
                end
            end
            hss_pkg::CMD_SYNC: begin
                unique case (sync_mode_reg)
                    hss_pkg::SYNC_START_SEEK: begin
                        if (mode_reg == hss_pkg::M_SYNCWAIT) begin
                            mode_next = hss_pkg::M_SEEK;
                        end
                    end
                    hss_pkg::SYNC_STEP_FWD:  do_fwd = 1'b1;
                    hss_pkg::SYNC_STEP_BACK: do_back = 1'b1;
                    default: ;
                endcase
            end
            hss_pkg::CMD_RUN_FWD: begin
                mode_next = hss_pkg::M_FWD;
                rate_next = s_rate_value;
            end
            hss_pkg::CMD_RUN_REV: begin
                mode_next = hss_pkg::M_REV;
                rate_next = s_rate_value;
            end
            hss_pkg::CMD_LOAD_POS: position_next = ld_w;
            hss_pkg::CMD_SEEK: begin
                target_next = tgt_w;
                mode_next   = (sync_mode_reg == hss_pkg::SYNC_START_SEEK) ?
                              hss_pkg::M_SYNCWAIT : hss_pkg::M_SEEK;
                rate_next   = s_rate_value;
            end
            hss_pkg::CMD_RELEASE: begin
                pattern_next = 4'b0000;
                mode_next    = hss_pkg::M_IDLE;
            end
            hss_pkg::CMD_CALIBRATE: begin
                mode_next = hss_pkg::M_FINDMIN;
                rate_next = s_rate_value;
            end
            hss_pkg::CMD_DDA: begin
                target_next = tgt_w;
                minor_next  = s_minor_delta;
                err_next    = '0;
                major_next  = MB'(diff[PB] ? -diff : diff);
                mode_next   = hss_pkg::M_DDA;
                rate_next   = s_rate_value;
            end
            default: ;
        endcase

        if (do_fwd) begin
            position_next = position_reg + PB'(1);
            phase_next    = phase_fwd;
            pattern_next  = hss_pkg::phase_pattern(phase_fwd);
        end else if (do_back) begin
            position_next = position_reg - PB'(1);
            phase_next    = phase_back;
            pattern_next  = hss_pkg::phase_pattern(phase_back);
        end

        if (notify_addr_reg == hss_pkg::NO_NOTIFY) begin
            notify = 1'b0;
        end
    end

    assign pos_out_ext = 32'(position_next);
    assign max_out_ext = 32'(max_found_next);

    always_comb begin
        res.coil_drive   = pattern_next;
        res.position     = pos_out_ext[15:0];
        res.range_max    = max_out_ext[15:0];
        res.run_rate     = rate_next;
        res.mode         = mode_next;
        res.sync_pulse   = pulse;
        res.notify_valid = notify;
        res.notify_kind  = notify ? kind : hss_pkg::KIND_SEEK;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            notify_addr_reg <= hss_pkg::NO_NOTIFY;
            sync_mode_reg   <= hss_pkg::SYNC_OFF;
        end else if (cfg_wr_en) begin
            if (cfg_index == hss_pkg::CFG_NOTIFY_ADDR) begin
                notify_addr_reg <= cfg_wdata;
            end else if (cfg_index == hss_pkg::CFG_SYNC_MODE) begin
                sync_mode_reg <= cfg_wdata[1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= '0;
            pattern_reg   <= '0;
            position_reg  <= '0;
            target_reg    <= '0;
            max_found_reg <= '0;
            mode_reg      <= hss_pkg::M_IDLE;
            rate_reg      <= '0;
            err_reg       <= '0;
            major_reg     <= '0;
            minor_reg     <= '0;
        end else if (accept) begin
            phase_reg     <= phase_next;
            pattern_reg   <= pattern_next;
            position_reg  <= position_next;
            target_reg    <= target_next;
            max_found_reg <= max_found_next;
            mode_reg      <= mode_next;
            rate_reg      <= rate_next;
            err_reg       <= err_next;
            major_reg     <= major_next;
            minor_reg     <= minor_next;
        end
    end

    // result register with one skid entry behind it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (out_free) begin
                if (skid_valid_reg) begin
                    out_valid_reg  <= 1'b1;
                    skid_valid_reg <= 1'b0;
                end else begin
                    out_valid_reg <= accept;
                end
            end else if (accept) begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free) begin
            out_reg <= skid_valid_reg ? skid_reg : res;
        end
        if (accept && !out_free) begin
            skid_reg <= res;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_coil_drive   = out_reg.coil_drive;
    assign m_position     = out_reg.position;
    assign m_range_max    = out_reg.range_max;
    assign m_run_rate     = out_reg.run_rate;
    assign m_mode         = out_reg.mode;
    assign m_sync_pulse   = out_reg.sync_pulse;
    assign m_notify_valid = out_reg.notify_valid;
    assign m_notify_kind  = out_reg.notify_kind;

    // skid entry only fills behind a held result
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry valid without result beat");

    // minor-axis strobe only while a DDA move keeps going
    a_pulse_in_dda: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_sync_pulse) |-> (m_mode == hss_pkg::M_DDA))
        else $error("sync pulse outside DDA mode");

    // calibration notice leaves the block idle
    a_calib_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_notify_valid && m_notify_kind) |-> (m_mode == hss_pkg::M_IDLE))
        else $error("calibration notice with block not idle");

    // seek arrival notice stops the timer and stays in seek
    a_seek_stop: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_notify_valid && !m_notify_kind) |->
        (m_mode == hss_pkg::M_SEEK && m_run_rate == 8'd0))
        else $error("seek notice with timer running");

    // a stalled beat leaves the state untouched
    a_no_accept_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (skid_valid_reg && $past(skid_valid_reg)) |-> $stable(position_reg))
        else $error("position changed while input stalled");

endmodule

### sim/tb_half_step_stepper_controller.sv
`timescale 1ns / 1ps
// Self-checking bench for half_step_stepper_controller: directed command checks, then random
// move sequences under random valid/ready gaps, each result beat compared with a local predictor.
// Depends on hss_pkg and the controller RTL.
module tb_half_step_stepper_controller;
    import hss_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int RANDOM_BEATS  = 600;
    localparam int RANDOM_PHASES = 6;

    localparam logic [3:0] CMD_UNUSED_LO = 4'd9;
    localparam logic [3:0] CMD_UNUSED_HI = 4'd15;

    // half-step coil sequence, phase 0 in the low nibble
    localparam logic [31:0] HALF_STEP_COILS = {4'b1001, 4'b1000, 4'b1100, 4'b0100,
                                               4'b0110, 4'b0010, 4'b0011, 4'b0001};

    typedef enum {
        RUN_BURST, LOAD_EDGE, SEEK_MOVE, CALIB_PASS, DDA_MOVE, STROBES, NOISE, RELEASE_STOP
    } traffic_kind_t;

    logic                       aclk;
    logic                       aresetn;
    logic                       cfg_wr_en;
    logic [CFG_INDEX_BITS-1:0]  cfg_index;
    logic [CFG_DATA_BITS-1:0]   cfg_wdata;
    logic                       s_valid;
    logic                       s_ready;
    logic [3:0]                 s_cmd;
    logic [7:0]                 s_rate_value;
    logic signed [15:0]         s_target_position;
    logic signed [15:0]         s_load_value;
    logic signed [15:0]         s_minor_delta;
    logic                       s_min_switch_n;
    logic                       s_max_switch_n;
    logic                       m_valid;
    logic                       m_ready;
    logic [3:0]                 m_coil_drive;
    logic signed [15:0]         m_position;
    logic signed [15:0]         m_range_max;
    logic [7:0]                 m_run_rate;
    logic [2:0]                 m_mode;
    logic                       m_sync_pulse;
    logic                       m_notify_valid;
    logic                       m_notify_kind;

    // predicted controller state
    logic [2:0]                 coil_step;
    logic [3:0]                 coil_bits;
    logic signed [15:0]         pos_count;
    logic signed [15:0]         seek_goal;
    logic signed [15:0]         range_seen;
    mode_t                      cur_mode;
    logic [7:0]                 tick_rate;
    logic [17:0]                dda_err;
    logic [16:0]                dda_span;
    logic signed [15:0]         dda_minor_inc;
    logic [7:0]                 notify_dest;
    logic [1:0]                 strobe_action;

    result_t expected_states[$];

    int errors;
    int beats_sent;
    int results_seen;
    int seek_notices;
    int calib_notices;
    int dda_pulses;
    int cycle_count;
    bit no_idle;

    half_step_stepper_controller dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_index         (cfg_index),
        .cfg_wdata         (cfg_wdata),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_cmd             (s_cmd),
        .s_rate_value      (s_rate_value),
        .s_target_position (s_target_position),
        .s_load_value      (s_load_value),
        .s_minor_delta     (s_minor_delta),
        .s_min_switch_n    (s_min_switch_n),
        .s_max_switch_n    (s_max_switch_n),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_coil_drive      (m_coil_drive),
        .m_position        (m_position),
        .m_range_max       (m_range_max),
        .m_run_rate        (m_run_rate),
        .m_mode            (m_mode),
        .m_sync_pulse      (m_sync_pulse),
        .m_notify_valid    (m_notify_valid),
        .m_notify_kind     (m_notify_kind)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                     expected_states.size());
            $display("half_step_stepper_controller: mismatch");
            $finish;
        end
    end

    // ---------------- predictor ----------------

    function automatic void step_forward();
        pos_count = pos_count + 16'sd1;
        coil_step = coil_step + 3'd1;
        coil_bits = HALF_STEP_COILS[coil_step*4 +: 4];
    endfunction

    function automatic void step_backward();
        pos_count = pos_count - 16'sd1;
        coil_step = coil_step - 3'd1;
        coil_bits = HALF_STEP_COILS[coil_step*4 +: 4];
    endfunction

    task automatic apply_event(input logic [3:0] cmd, input logic [7:0] rate_in,
                               input logic signed [15:0] tgt, input logic signed [15:0] ld,
                               input logic signed [15:0] minor, input logic min_n,
                               input logic max_n);
        result_t r;
        logic    pulse;
        logic    notice;
        logic    notice_kind;
        int      acc;
        int      span_len;
        pulse       = 1'b0;
        notice      = 1'b0;
        notice_kind = KIND_SEEK;
        case (cmd)
            CMD_TICK: begin
                if (tick_rate != 8'd0) begin
                    case (cur_mode)
                        M_IDLE: tick_rate = 8'd0;
                        M_FWD:  step_forward();
                        M_REV:  step_backward();
                        M_SEEK: begin
                            if (pos_count < seek_goal) begin
                                step_forward();
                            end else if (pos_count > seek_goal) begin
                                step_backward();
                            end else begin
                                tick_rate   = 8'd0;
                                notice      = 1'b1;
                                notice_kind = KIND_SEEK;
                            end
                        end
                        M_FINDMIN: begin
                            if (!min_n) begin
                                pos_count = 16'sd0;
                                cur_mode  = M_FINDMAX;
                            end else begin
                                step_backward();
                            end
                        end
                        M_FINDMAX: begin
                            if (!max_n) begin
                                range_seen  = pos_count;
                                cur_mode    = M_IDLE;
                                notice      = 1'b1;
                                notice_kind = KIND_CALIB;
                            end else begin
                                step_forward();
                            end
                        end
                        M_DDA: begin
                            if (pos_count == seek_goal) begin
                                cur_mode  = M_IDLE;
                                tick_rate = 8'd0;
                            end else begin
                                if (pos_count < seek_goal)
                                    step_forward();
                                else
                                    step_backward();
                                // error term wraps at 18 bits before the compare
                                acc = int'($signed(dda_err)) + int'(dda_minor_inc);
                                acc = int'($signed(acc[17:0]));
                                if (2 * acc > int'(dda_span)) begin
                                    pulse = 1'b1;
                                    acc   = acc - int'(dda_span);
                                end
                                dda_err = acc[17:0];
                            end
                        end
                        default: ;
                    endcase
                end
            end
            CMD_SYNC: begin
                case (strobe_action)
                    SYNC_START_SEEK: if (cur_mode == M_SYNCWAIT) cur_mode = M_SEEK;
                    SYNC_STEP_FWD:   step_forward();
                    SYNC_STEP_BACK:  step_backward();
                    default: ;
                endcase
            end
            CMD_RUN_FWD: begin
                cur_mode  = M_FWD;
                tick_rate = rate_in;
            end
            CMD_RUN_REV: begin
                cur_mode  = M_REV;
                tick_rate = rate_in;
            end
            CMD_LOAD_POS: pos_count = ld;
            CMD_SEEK: begin
                seek_goal = tgt;
                cur_mode  = (strobe_action == SYNC_START_SEEK) ? M_SYNCWAIT : M_SEEK;
                tick_rate = rate_in;
            end
            CMD_RELEASE: begin
                coil_bits = 4'd0;
                cur_mode  = M_IDLE;
            end
            CMD_CALIBRATE: begin
                cur_mode  = M_FINDMIN;
                tick_rate = rate_in;
            end
            CMD_DDA: begin
                seek_goal     = tgt;
                dda_minor_inc = minor;
                dda_err       = 18'd0;
                span_len      = int'(tgt) - int'(pos_count);
                if (span_len < 0)
                    span_len = -span_len;
                dda_span  = span_len[16:0];
                cur_mode  = M_DDA;
                tick_rate = rate_in;
            end
            default: ;
        endcase
        if (notify_dest == NO_NOTIFY) begin
            notice      = 1'b0;
            notice_kind = KIND_SEEK;
        end
        r.coil_drive   = coil_bits;
        r.position     = pos_count;
        r.range_max    = range_seen;
        r.run_rate     = tick_rate;
        r.mode         = cur_mode;
        r.sync_pulse   = pulse;
        r.notify_valid = notice;
        r.notify_kind  = notice ? notice_kind : KIND_SEEK;
        expected_states.push_back(r);
    endtask

    // ---------------- result check ----------------

    task automatic check_field(input string what, input int want, input int got);
        if (want != got) begin
            errors++;
            $display("%0t: %s expected %0d, got %0d", $time, what, want, got);
        end
    endtask

    always @(posedge aclk) begin
        result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_states.size() == 0) begin
                errors++;
                $display("%0t: result beat with nothing expected (position %0d)", $time,
                         m_position);
            end else begin
                want = expected_states.pop_front();
                results_seen++;
                if (want.notify_valid && want.notify_kind == KIND_CALIB)
                    calib_notices++;
                else if (want.notify_valid)
                    seek_notices++;
                if (want.sync_pulse)
                    dda_pulses++;
                check_field("coil_drive", int'(want.coil_drive), int'(m_coil_drive));
                check_field("position", int'(want.position), int'(m_position));
                check_field("range_max", int'(want.range_max), int'(m_range_max));
                check_field("run_rate", int'(want.run_rate), int'(m_run_rate));
                check_field("mode", int'(want.mode), int'(m_mode));
                check_field("sync_pulse", int'(want.sync_pulse), int'(m_sync_pulse));
                check_field("notify_valid", int'(want.notify_valid), int'(m_notify_valid));
                check_field("notify_kind", int'(want.notify_kind), int'(m_notify_kind));
            end
        end
    end

    // receiver: random stall before each result beat
    initial begin
        int hold;
        m_ready = 1'b0;
        @(posedge aclk);
        forever begin
            hold = no_idle ? 0 : $urandom_range(0, 7);
            if (hold > 0) begin
                m_ready <= 1'b0;
                repeat (hold) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    // ---------------- stimulus helpers ----------------

    function automatic bit coin();
        return bit'($urandom_range(0, 1));
    endfunction

    function automatic logic [7:0] rand8();
        return 8'($urandom);
    endfunction

    function automatic logic [15:0] rand16();
        return 16'($urandom);
    endfunction

    function automatic logic [7:0] draw_rate();
        return ($urandom_range(0, 7) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
    endfunction

    function automatic int rand_offset(input int lim);
        return int'($urandom_range(0, 2 * lim)) - lim;
    endfunction

    // target a short way from the current position, never across the wrap
    function automatic logic signed [15:0] near_position(input int off);
        int t;
        t = int'(pos_count) + off;
        if (t > 32767 || t < -32768)
            t = int'(pos_count) - off;
        return t[15:0];
    endfunction

    task automatic send_beat(input logic [3:0] cmd, input logic [7:0] rate_in,
                             input logic signed [15:0] tgt, input logic signed [15:0] ld,
                             input logic signed [15:0] minor, input logic min_n,
                             input logic max_n);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid           <= 1'b1;
        s_cmd             <= cmd;
        s_rate_value      <= rate_in;
        s_target_position <= tgt;
        s_load_value      <= ld;
        s_minor_delta     <= minor;
        s_min_switch_n    <= min_n;
        s_max_switch_n    <= max_n;
        do @(posedge aclk); while (!s_ready);
        apply_event(cmd, rate_in, tgt, ld, minor, min_n, max_n);
        beats_sent++;
    endtask

    task automatic tick(input logic min_n, input logic max_n);
        send_beat(CMD_TICK, rand8(), rand16(), rand16(), rand16(), min_n, max_n);
    endtask

    task automatic issue_command(input logic [3:0] cmd, input logic [7:0] rate_in,
                                 input logic signed [15:0] tgt, input logic signed [15:0] ld,
                                 input logic signed [15:0] minor);
        send_beat(cmd, rate_in, tgt, ld, minor, coin(), coin());
    endtask

    // wait for every result, then let the output register drain
    task automatic settle();
        s_valid <= 1'b0;
        while (expected_states.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic set_config(input logic [7:0] dest, input logic [1:0] action);
        settle();
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_NOTIFY_ADDR;
        cfg_wdata <= dest;
        @(posedge aclk);
        cfg_index <= CFG_SYNC_MODE;
        cfg_wdata <= CFG_DATA_BITS'(action);
        @(posedge aclk);
        cfg_wr_en     <= 1'b0;
        notify_dest   = dest;
        strobe_action = action;
    endtask

    // ---------------- tests ----------------

    task automatic test_stopped_and_unused();
        set_config(NO_NOTIFY, SYNC_OFF);
        tick(1'b1, 1'b1);   // timer not running yet
        issue_command(CMD_UNUSED_LO, 8'hFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
        issue_command(CMD_UNUSED_HI, 8'h00, 16'sh8000, 16'sh8000, 16'sh8000);
        issue_command(CMD_SYNC, rand8(), rand16(), rand16(), rand16());
    endtask

    task automatic test_run_and_wrap();
        issue_command(CMD_LOAD_POS, rand8(), rand16(), 16'sh7FFF, rand16());
        issue_command(CMD_RUN_FWD, 8'd255, rand16(), rand16(), rand16());
        tick(1'b1, 1'b1);
        issue_command(CMD_RUN_REV, 8'd1, rand16(), rand16(), rand16());
        tick(1'b0, 1'b0);
        issue_command(CMD_RELEASE, rand8(), rand16(), rand16(), rand16());
        tick(1'b1, 1'b1);   // idle tick clears the rate
    endtask

    task automatic test_sync_seek();
        set_config(8'd0, SYNC_START_SEEK);
        issue_command(CMD_SYNC, rand8(), rand16(), rand16(), rand16());
        issue_command(CMD_SEEK, 8'd128, near_position(-1), rand16(), rand16());
        tick(1'b1, 1'b1);   // held in sync wait
        issue_command(CMD_SYNC, rand8(), rand16(), rand16(), rand16());
        tick(1'b1, 1'b1);
        tick(1'b1, 1'b1);   // arrival, notice sent
    endtask

    task automatic test_calibration();
        set_config(8'd1, SYNC_OFF);
        issue_command(CMD_CALIBRATE, 8'd7, rand16(), rand16(), rand16());
        tick(1'b1, 1'b1);
        tick(1'b0, 1'b1);
        tick(1'b1, 1'b1);
        tick(1'b1, 1'b0);
    endtask

    task automatic test_dda();
        issue_command(CMD_LOAD_POS, rand8(), rand16(), 16'sd1, rand16());
        issue_command(CMD_DDA, 8'd1, 16'sd3, rand16(), 16'sd2);
        repeat (3) tick(1'b1, 1'b1);
        issue_command(CMD_LOAD_POS, rand8(), rand16(), 16'sh8000, rand16());
        issue_command(CMD_DDA, 8'd255, 16'sh7FFF, rand16(), 16'sh8000);
        tick(1'b1, 1'b1);
    endtask

    task automatic test_strobe_steps();
        set_config(8'd128, SYNC_STEP_FWD);
        issue_command(CMD_SYNC, rand8(), rand16(), rand16(), rand16());
        set_config(NO_NOTIFY, SYNC_STEP_BACK);
        issue_command(CMD_SYNC, rand8(), rand16(), rand16(), rand16());
    endtask

    task automatic test_random_traffic();
        int            phase;
        int            first;
        int            n;
        int            ld;
        logic [7:0]    dest;
        logic [1:0]    action;
        traffic_kind_t kind;
        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase)
                0:       begin dest = NO_NOTIFY;                  action = SYNC_OFF;        end
                1:       begin dest = 8'd0;                       action = SYNC_START_SEEK; end
                2:       begin dest = 8'($urandom_range(0, 254)); action = SYNC_STEP_FWD;   end
                3:       begin dest = NO_NOTIFY;                  action = SYNC_STEP_BACK;  end
                4:       begin dest = 8'($urandom_range(0, 254)); action = SYNC_START_SEEK; end
                default: begin dest = rand8();                    action = 2'($urandom);    end
            endcase
            set_config(dest, action);
            no_idle = (phase == 2);
            first   = beats_sent;
            while (beats_sent - first < RANDOM_BEATS / RANDOM_PHASES) begin
                kind = traffic_kind_t'($urandom_range(0, 7));
                case (kind)
                    RUN_BURST: begin
                        issue_command(coin() ? CMD_RUN_FWD : CMD_RUN_REV, draw_rate(),
                                      rand16(), rand16(), rand16());
                        repeat ($urandom_range(1, 10)) tick(coin(), coin());
                    end
                    LOAD_EDGE: begin
                        if (coin())
                            ld = int'($urandom);
                        else if (coin())
                            ld = 32760 + $urandom_range(0, 7);
                        else
                            ld = -32768 + $urandom_range(0, 7);
                        issue_command(CMD_LOAD_POS, rand8(), rand16(), 16'(ld), rand16());
                    end
                    SEEK_MOVE: begin
                        issue_command(CMD_SEEK, draw_rate(), near_position(rand_offset(12)),
                                      rand16(), rand16());
                        n = 0;
                        while ((cur_mode == M_SEEK || cur_mode == M_SYNCWAIT)
                               && tick_rate != 8'd0 && n < 40) begin
                            if (cur_mode == M_SYNCWAIT && coin())
                                issue_command(CMD_SYNC, rand8(), rand16(), rand16(), rand16());
                            else
                                tick(coin(), coin());
                            n++;
                        end
                        tick(coin(), coin());
                    end
                    CALIB_PASS: begin
                        issue_command(CMD_CALIBRATE, draw_rate(), rand16(), rand16(), rand16());
                        repeat ($urandom_range(0, 5)) tick(1'b1, coin());
                        tick(1'b0, coin());
                        repeat ($urandom_range(0, 5)) tick(coin(), 1'b1);
                        tick(coin(), 1'b0);
                        if (coin())
                            tick(coin(), coin());
                    end
                    DDA_MOVE: begin
                        issue_command(CMD_DDA, draw_rate(), near_position(rand_offset(16)),
                                      rand16(),
                                      16'(coin() ? int'($urandom) : rand_offset(20)));
                        n = 0;
                        while (cur_mode == M_DDA && tick_rate != 8'd0 && n < 40) begin
                            tick(coin(), coin());
                            n++;
                        end
                    end
                    STROBES: begin
                        repeat ($urandom_range(1, 4))
                            issue_command(CMD_SYNC, rand8(), rand16(), rand16(), rand16());
                        tick(coin(), coin());
                    end
                    NOISE: begin
                        repeat ($urandom_range(1, 5))
                            send_beat(4'($urandom), rand8(), rand16(), rand16(), rand16(),
                                      coin(), coin());
                    end
                    default: begin
                        issue_command(CMD_RELEASE, rand8(), rand16(), rand16(), rand16());
                        repeat ($urandom_range(0, 2)) tick(coin(), coin());
                    end
                endcase
            end
        end
        no_idle = 1'b0;
    endtask

    initial begin
        aresetn           = 1'b0;
        cfg_wr_en         = 1'b0;
        cfg_index         = CFG_NOTIFY_ADDR;
        cfg_wdata         = '0;
        s_valid           = 1'b0;
        s_cmd             = CMD_TICK;
        s_rate_value      = '0;
        s_target_position = '0;
        s_load_value      = '0;
        s_minor_delta     = '0;
        s_min_switch_n    = 1'b1;
        s_max_switch_n    = 1'b1;
        no_idle           = 1'b0;
        coil_step         = '0;
        coil_bits         = '0;
        pos_count         = '0;
        seek_goal         = '0;
        range_seen        = '0;
        cur_mode          = M_IDLE;
        tick_rate         = '0;
        dda_err           = '0;
        dda_span          = '0;
        dda_minor_inc     = '0;
        notify_dest       = NO_NOTIFY;
        strobe_action     = SYNC_OFF;
        errors            = 0;
        beats_sent        = 0;
        results_seen      = 0;
        seek_notices      = 0;
        calib_notices     = 0;
        dda_pulses        = 0;
        cycle_count       = 0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_stopped_and_unused();
        test_run_and_wrap();
        test_sync_seek();
        test_calibration();
        test_dda();
        test_strobe_steps();
        test_random_traffic();
        settle();

        $display("%0d command beats in, %0d result beats checked, %0d errors", beats_sent,
                 results_seen, errors);
        $display("seek notices %0d, calibration notices %0d, dda sync pulses %0d",
                 seek_notices, calib_notices, dda_pulses);
        if (errors == 0 && expected_states.size() == 0)
            $display("half_step_stepper_controller: match");
        else
            $display("half_step_stepper_controller: mismatch");
        $finish;
    end

endmodule
